@@ rtl/asp_pkg.sv @@
// Package for the animation phase sequencer: fixed-point widths, opcode,
// play mode and register index codes.
// No dependencies; imported by animation_phase_sequencer.
`timescale 1ns / 1ps
`default_nettype none

package asp_pkg;

    localparam int PHASE_FRAC_BITS = 16;
    localparam int RATE_FRAC_BITS  = 24;

    localparam int PHASE_W   = PHASE_FRAC_BITS + 1;
    localparam int ELAPSED_W = 16;
    localparam int RATE_W    = 28;
    localparam int PROD_W    = ELAPSED_W + RATE_W;

    // Scaling from rate fraction bits to phase fraction bits.
    localparam int RSHIFT = (RATE_FRAC_BITS >= PHASE_FRAC_BITS) ?
                            (RATE_FRAC_BITS - PHASE_FRAC_BITS) : 0;
    localparam int LSHIFT = (PHASE_FRAC_BITS > RATE_FRAC_BITS) ?
                            (PHASE_FRAC_BITS - RATE_FRAC_BITS) : 0;
    localparam int DELTA_W = PROD_W - RSHIFT + LSHIFT;

    localparam logic [PHASE_W-1:0] PHASE_ONE  = PHASE_W'(1) << PHASE_FRAC_BITS;
    localparam logic [PHASE_W-1:0] PHASE_ZERO = '0;

    localparam int MODE_W = 3;
    localparam int CFG_W  = RATE_W;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_PLAY    = 3'd1,
        OP_PAUSE   = 3'd2,
        OP_STOP    = 3'd3,
        OP_RESET   = 3'd4,
        OP_SET_POS = 3'd5
    } opcode_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_FWD    = 3'd0,
        MODE_REV    = 3'd1,
        MODE_PP     = 3'd2,
        MODE_REV_PP = 3'd3,
        MODE_STATIC = 3'd4
    } play_mode_t;

    typedef enum logic [1:0] {
        CFG_PLAY_MODE   = 2'd0,
        CFG_LOOP_ENABLE = 2'd1,
        CFG_STEP_RATE   = 2'd2,
        CFG_CLIP_LOADED = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic play;
        logic start;
        logic end_pt;
        logic change;
        logic stop;
        logic pause_on;
        logic pause_off;
    } events_t;

endpackage : asp_pkg

`default_nettype wire

@@ rtl/animation_phase_sequencer.sv @@
// Animation phase sequencer: one request in, one result out, every cycle while
// neither side stalls. A request is taken into an input stage with the product
// of elapsed and step_rate; from there it is applied to the playback state and
// loads the result register once that register is free or drains. One request
// can be accepted per cycle while nothing stalls; the state update (add, wrap or
// reflect) is the registered feedback loop that sets that rate. The input stage
// keeps accepting while a finished result waits, until both stages are full.
// Configuration must only be written while no request is in flight.
// Depends on asp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module animation_phase_sequencer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration
    input  wire logic                           cfg_wr_en,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [asp_pkg::CFG_W-1:0]      cfg_data,
    // requests
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [2:0]                     opcode,
    input  wire logic [asp_pkg::ELAPSED_W-1:0]  elapsed,
    input  wire logic [asp_pkg::PHASE_W-1:0]    new_position,
    // results
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [asp_pkg::PHASE_W-1:0]         phase,
    output logic                                is_playing,
    output logic                                is_paused,
    output logic                                forward,
    output logic                                ev_play,
    output logic                                ev_start,
    output logic                                ev_end,
    output logic                                ev_change,
    output logic                                ev_stop,
    output logic                                ev_pause_on,
    output logic                                ev_pause_off
);
    import asp_pkg::*;

    localparam int FRAC = PHASE_FRAC_BITS;

    // Configuration registers.
    logic [MODE_W-1:0]  play_mode_reg;
    logic               loop_enable_reg;
    logic [RATE_W-1:0]  step_rate_reg;
    logic               clip_loaded_reg;

    // Playback state.
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               dir_reg, dir_next;
    logic               playing_reg, playing_next;
    logic               paused_reg, paused_next;
    events_t            ev_next;

    // Input stage.
    logic               s1_valid_reg;
    opcode_t            s1_opcode_reg;
    logic [DELTA_W-1:0] s1_delta_reg;
    logic [PHASE_W-1:0] s1_newpos_reg;

    // Result register.
    logic               out_valid_reg;
    logic [PHASE_W-1:0] out_phase_reg;
    logic               out_playing_reg;
    logic               out_paused_reg;
    logic               out_forward_reg;
    events_t            out_ev_reg;

    logic                      advance;
    logic                      in_accept;
    logic [PROD_W-1:0]         prod;
    logic [PROD_W+LSHIFT-1:0]  prod_wide;
    logic [DELTA_W-1:0]        delta;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            play_mode_reg   <= '0;
            loop_enable_reg <= 1'b0;
            step_rate_reg   <= '0;
            clip_loaded_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PLAY_MODE:   play_mode_reg   <= cfg_data[MODE_W-1:0];
                CFG_LOOP_ENABLE: loop_enable_reg <= cfg_data[0];
                CFG_STEP_RATE:   step_rate_reg   <= cfg_data[RATE_W-1:0];
                CFG_CLIP_LOADED: clip_loaded_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // The input stage moves on when the result register is free or drains.
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        prod      = PROD_W'(elapsed) * PROD_W'(step_rate_reg);
        prod_wide = (PROD_W + LSHIFT)'(prod) << LSHIFT;
        delta     = DELTA_W'(prod_wide >> RSHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_opcode_reg <= opcode_t'(opcode);
            s1_delta_reg  <= delta;
            s1_newpos_reg <= new_position;
        end
    end

    // State update for the request in the input stage.
    logic                 start_rev;
    logic [PHASE_W-1:0]   start_phase;
    logic                 tick_active;
    logic                 going_up;
    logic [DELTA_W:0]     up_sum;
    logic                 up_over;
    logic [FRAC-1:0]      up_mod;
    logic [DELTA_W:0]     down_diff;
    logic                 down_ge;
    logic                 down_gt;
    logic [FRAC-1:0]      down_mod;
    logic [PHASE_W-1:0]   up_reflect;
    logic [PHASE_W-1:0]   down_wrap;
    logic                 stopped;

    always_comb
    begin
        start_rev   = clip_loaded_reg &&
                      ((play_mode_reg == MODE_REV) || (play_mode_reg == MODE_REV_PP));
        start_phase = start_rev ? PHASE_ONE : PHASE_ZERO;
        tick_active = clip_loaded_reg && playing_reg && !paused_reg &&
                      (play_mode_reg < MODE_STATIC);
        going_up    = (play_mode_reg == MODE_FWD) ||
                      ((play_mode_reg >= MODE_PP) && dir_reg);

        up_sum      = (DELTA_W + 1)'(phase_reg) + (DELTA_W + 1)'(s1_delta_reg);
        up_over     = up_sum >= (DELTA_W + 1)'(PHASE_ONE);
        up_mod      = up_sum[FRAC-1:0];
        up_reflect  = PHASE_ONE - PHASE_W'(up_mod);

        // Bit DELTA_W of the difference is the borrow: set when delta < phase.
        down_diff   = (DELTA_W + 1)'(s1_delta_reg) - (DELTA_W + 1)'(phase_reg);
        down_ge     = !down_diff[DELTA_W];
        down_gt     = down_ge && (down_diff[DELTA_W-1:0] != '0);
        down_mod    = down_diff[FRAC-1:0];
        down_wrap   = PHASE_ONE - PHASE_W'(down_mod);

        phase_next   = phase_reg;
        dir_next     = dir_reg;
        playing_next = playing_reg;
        paused_next  = paused_reg;
        ev_next      = '0;
        stopped      = 1'b0;

        case (s1_opcode_reg)
            OP_TICK:
            begin
                if (tick_active)
                begin
                    if (going_up)
                    begin
                        if (!up_over)
                        begin
                            phase_next = PHASE_W'(up_sum);
                        end
                        else if (play_mode_reg == MODE_PP)
                        begin
                            // Turn at the top, reflected once only.
                            phase_next     = up_reflect;
                            dir_next       = 1'b0;
                            ev_next.change = 1'b1;
                        end
                        else
                        begin
                            ev_next.end_pt = 1'b1;
                            if (loop_enable_reg)
                            begin
                                ev_next.start = 1'b1;
                                if (play_mode_reg == MODE_FWD)
                                begin
                                    phase_next = PHASE_W'(up_mod);
                                end
                                else
                                begin
                                    phase_next = up_reflect;
                                    dir_next   = 1'b0;
                                end
                            end
                            else
                            begin
                                stopped = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        if (!((play_mode_reg == MODE_REV) ? down_ge : down_gt))
                        begin
                            phase_next = phase_reg - PHASE_W'(s1_delta_reg);
                        end
                        else if (play_mode_reg == MODE_REV_PP)
                        begin
                            phase_next     = PHASE_W'(down_mod);
                            dir_next       = 1'b1;
                            ev_next.change = 1'b1;
                        end
                        else
                        begin
                            ev_next.end_pt = 1'b1;
                            if (loop_enable_reg)
                            begin
                                ev_next.start = 1'b1;
                                if (play_mode_reg == MODE_REV)
                                begin
                                    phase_next = down_wrap;
                                end
                                else
                                begin
                                    phase_next = PHASE_W'(down_mod);
                                    dir_next   = 1'b1;
                                end
                            end
                            else
                            begin
                                stopped = 1'b1;
                            end
                        end
                    end

                    if (stopped)
                    begin
                        playing_next = 1'b0;
                        paused_next  = 1'b0;
                        ev_next.stop = 1'b1;
                        phase_next   = start_phase;
                        dir_next     = !start_rev;
                    end
                end
            end
            OP_PLAY:
            begin
                if (clip_loaded_reg && !(playing_reg && !paused_reg))
                begin
                    playing_next = 1'b1;
                    paused_next  = 1'b0;
                    if (paused_reg)
                    begin
                        ev_next.pause_off = 1'b1;
                    end
                    else
                    begin
                        ev_next.play  = 1'b1;
                        ev_next.start = 1'b1;
                    end
                end
            end
            OP_PAUSE:
            begin
                paused_next      = 1'b1;
                ev_next.pause_on = 1'b1;
            end
            OP_STOP:
            begin
                phase_next   = start_phase;
                dir_next     = !start_rev;
                playing_next = 1'b0;
                paused_next  = 1'b0;
                ev_next.stop = 1'b1;
            end
            OP_RESET:
            begin
                phase_next = start_phase;
                dir_next   = !start_rev;
            end
            OP_SET_POS:
            begin
                phase_next = (s1_newpos_reg > PHASE_ONE) ? PHASE_ONE : s1_newpos_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            dir_reg     <= 1'b1;
            playing_reg <= 1'b0;
            paused_reg  <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            dir_reg     <= dir_next;
            playing_reg <= playing_next;
            paused_reg  <= paused_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= advance || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_phase_reg   <= phase_next;
            out_playing_reg <= playing_next;
            out_paused_reg  <= paused_next;
            out_forward_reg <= dir_next;
            out_ev_reg      <= ev_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign phase        = out_phase_reg;
    assign is_playing   = out_playing_reg;
    assign is_paused    = out_paused_reg;
    assign forward      = out_forward_reg;
    assign ev_play      = out_ev_reg.play;
    assign ev_start     = out_ev_reg.start;
    assign ev_end       = out_ev_reg.end_pt;
    assign ev_change    = out_ev_reg.change;
    assign ev_stop      = out_ev_reg.stop;
    assign ev_pause_on  = out_ev_reg.pause_on;
    assign ev_pause_off = out_ev_reg.pause_off;

    // A request held in the input stage is not dropped while it waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> s1_valid_reg)
        else $error("input stage lost a waiting request");

    // The phase never leaves the range zero to one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (phase <= PHASE_ONE))
        else $error("phase out of range");

    // A stop leaves both flags clear and never comes with a cycle start.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ev_stop) |-> (!is_playing && !is_paused && !ev_start))
        else $error("stop result with inconsistent flags");

    // A ping-pong turn keeps playing and is not an end of cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ev_change) |-> (is_playing && !ev_end && !ev_stop))
        else $error("direction change with inconsistent flags");

endmodule : animation_phase_sequencer

`default_nettype wire

@@ bench/animation_phase_sequencer_tb.sv @@
// Self-checking testbench for animation_phase_sequencer: directed and random requests,
// predicted results checked field by field under random sender gaps and receiver stalls.
// Depends on asp_pkg and the animation_phase_sequencer RTL.
`timescale 1ns / 1ps

module animation_phase_sequencer_tb;

    import asp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD_CYCLES = 80;

    typedef struct packed {
        opcode_t                op;
        logic [ELAPSED_W-1:0]   elapsed;
        logic [PHASE_W-1:0]     new_pos;
    } request_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               playing;
        logic               paused;
        logic               fwd;
        events_t            ev;
    } playback_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [1:0]             cfg_index = CFG_PLAY_MODE;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [2:0]             opcode = OP_TICK;
    logic [ELAPSED_W-1:0]   elapsed = '0;
    logic [PHASE_W-1:0]     new_position = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [PHASE_W-1:0]     phase;
    logic                   is_playing;
    logic                   is_paused;
    logic                   forward;
    logic                   ev_play;
    logic                   ev_start;
    logic                   ev_end;
    logic                   ev_change;
    logic                   ev_stop;
    logic                   ev_pause_on;
    logic                   ev_pause_off;

    // Predicted playback state and configuration.
    longint unsigned    pos_q = 0;
    bit                 fwd_q = 1'b1;
    bit                 playing_q = 1'b0;
    bit                 paused_q = 1'b0;
    play_mode_t         mode_q = MODE_FWD;
    bit                 loop_q = 1'b0;
    logic [RATE_W-1:0]  rate_q = '0;
    bit                 clip_q = 1'b0;

    request_t   pending_requests[$];
    playback_t  awaited_results[$];
    request_t   cur_req;
    int         mismatches = 0;
    int         cycles = 0;
    int         burst_left = 0;
    int         gap_left = 0;
    int         hold_requests = 0;
    int         holds_served = 0;
    int         hold_left = 0;
    logic [7:0] stall_pat = '0;
    int         pat_age = 0;
    logic [2:0] pat_pos = '0;

    animation_phase_sequencer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .elapsed      (elapsed),
        .new_position (new_position),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .phase        (phase),
        .is_playing   (is_playing),
        .is_paused    (is_paused),
        .forward      (forward),
        .ev_play      (ev_play),
        .ev_start     (ev_start),
        .ev_end       (ev_end),
        .ev_change    (ev_change),
        .ev_stop      (ev_stop),
        .ev_pause_on  (ev_pause_on),
        .ev_pause_off (ev_pause_off)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void return_to_start();
        if (clip_q && (mode_q == MODE_REV || mode_q == MODE_REV_PP))
        begin
            pos_q = 64'(PHASE_ONE);
            fwd_q = 1'b0;
        end
        else
        begin
            pos_q = 0;
            fwd_q = 1'b1;
        end
    endfunction

    // Applies one request to the predicted state and returns the result it produces.
    function automatic playback_t advance_playback(request_t rq);
        playback_t          res;
        longint unsigned    one_q;
        longint unsigned    step_len;
        longint unsigned    sum;
        longint unsigned    overshoot;
        bit                 going_up;
        bit                 reached;
        bit                 halted;
        res = '0;
        halted = 1'b0;
        one_q = 64'(PHASE_ONE);
        case (rq.op)
            OP_TICK:
            begin
                if (clip_q && playing_q && !paused_q && mode_q < MODE_STATIC)
                begin
                    step_len = ((64'(rq.elapsed) * 64'(rate_q)) >> RSHIFT) << LSHIFT;
                    going_up = (mode_q == MODE_FWD) || (mode_q >= MODE_PP && fwd_q);
                    if (going_up)
                    begin
                        sum = pos_q + step_len;
                        if (sum < one_q)
                            pos_q = sum;
                        else if (mode_q == MODE_PP)
                        begin
                            // A ping-pong turn reflects once, however far the step reaches.
                            pos_q = one_q - sum % one_q;
                            fwd_q = 1'b0;
                            res.ev.change = 1'b1;
                        end
                        else
                        begin
                            res.ev.end_pt = 1'b1;
                            if (!loop_q)
                                halted = 1'b1;
                            else if (mode_q == MODE_FWD)
                            begin
                                pos_q = sum % one_q;
                                res.ev.start = 1'b1;
                            end
                            else
                            begin
                                pos_q = one_q - sum % one_q;
                                fwd_q = 1'b0;
                                res.ev.start = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        // Plain reverse ends on reaching zero; the ping-pong modes only past it.
                        reached = (mode_q == MODE_REV) ? (step_len >= pos_q) : (step_len > pos_q);
                        if (!reached)
                            pos_q = pos_q - step_len;
                        else
                        begin
                            overshoot = step_len - pos_q;
                            if (mode_q == MODE_REV_PP)
                            begin
                                pos_q = overshoot % one_q;
                                fwd_q = 1'b1;
                                res.ev.change = 1'b1;
                            end
                            else
                            begin
                                res.ev.end_pt = 1'b1;
                                if (!loop_q)
                                    halted = 1'b1;
                                else if (mode_q == MODE_REV)
                                begin
                                    pos_q = one_q - overshoot % one_q;
                                    res.ev.start = 1'b1;
                                end
                                else
                                begin
                                    pos_q = overshoot % one_q;
                                    fwd_q = 1'b1;
                                    res.ev.start = 1'b1;
                                end
                            end
                        end
                    end
                    if (halted)
                    begin
                        playing_q = 1'b0;
                        paused_q = 1'b0;
                        res.ev.stop = 1'b1;
                        return_to_start();
                    end
                end
            end
            OP_PLAY:
            begin
                if (clip_q && !(playing_q && !paused_q))
                begin
                    playing_q = 1'b1;
                    if (!paused_q)
                    begin
                        res.ev.play = 1'b1;
                        res.ev.start = 1'b1;
                    end
                    else
                        res.ev.pause_off = 1'b1;
                    paused_q = 1'b0;
                end
            end
            OP_PAUSE:
            begin
                paused_q = 1'b1;
                res.ev.pause_on = 1'b1;
            end
            OP_STOP:
            begin
                return_to_start();
                playing_q = 1'b0;
                paused_q = 1'b0;
                res.ev.stop = 1'b1;
            end
            OP_RESET:
                return_to_start();
            OP_SET_POS:
                pos_q = (rq.new_pos > PHASE_ONE) ? one_q : 64'(rq.new_pos);
            default:
            begin
            end
        endcase
        res.phase = pos_q[PHASE_W-1:0];
        res.playing = playing_q;
        res.paused = paused_q;
        res.fwd = fwd_q;
        return res;
    endfunction

    task automatic queue_request(input opcode_t op, input int unsigned el, input int unsigned pos);
        request_t rq;
        rq.op = op;
        rq.elapsed = ELAPSED_W'(el);
        rq.new_pos = PHASE_W'(pos);
        pending_requests.push_back(rq);
    endtask

    // Waits until every request is sent and every result is back, then lets the
    // pipeline settle before the caller touches the registers.
    task automatic drain();
        while (pending_requests.size() != 0 || in_valid || awaited_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic program_registers(input play_mode_t mode, input bit looped,
                                     input logic [RATE_W-1:0] rate, input bit clip);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_PLAY_MODE;
        cfg_data <= CFG_W'(mode);
        @(posedge clk);
        cfg_index <= CFG_LOOP_ENABLE;
        cfg_data <= CFG_W'(looped);
        @(posedge clk);
        cfg_index <= CFG_STEP_RATE;
        cfg_data <= CFG_W'(rate);
        @(posedge clk);
        cfg_index <= CFG_CLIP_LOADED;
        cfg_data <= CFG_W'(clip);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        mode_q = mode;
        loop_q = looped;
        rate_q = rate;
        clip_q = clip;
        @(negedge clk);
    endtask

    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Sender: bursts of requests separated by random gaps.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                awaited_results.push_back(advance_playback(cur_req));
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    cur_req = pending_requests.pop_front();
                    in_valid <= 1'b1;
                    opcode <= cur_req.op;
                    elapsed <= cur_req.elapsed;
                    new_position <= cur_req.new_pos;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls on a rotating pattern, with an occasional long hold-off.
    always @(posedge clk)
    begin
        if (holds_served != hold_requests)
        begin
            holds_served++;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (pat_age == 0)
            begin
                case ($urandom_range(0, 3))
                    0: stall_pat = 8'h00;
                    1: stall_pat = 8'($urandom);
                    2: stall_pat = 8'($urandom) & 8'($urandom);
                    default: stall_pat = 8'($urandom) | 8'($urandom);
                endcase
                pat_age = 24;
            end
            pat_age--;
            out_stall <= stall_pat[pat_pos];
            pat_pos <= pat_pos + 3'd1;
        end
    end

    always @(posedge clk)
    begin : result_check
        playback_t got;
        playback_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.phase = phase;
            got.playing = is_playing;
            got.paused = is_paused;
            got.fwd = forward;
            got.ev.play = ev_play;
            got.ev.start = ev_start;
            got.ev.end_pt = ev_end;
            got.ev.change = ev_change;
            got.ev.stop = ev_stop;
            got.ev.pause_on = ev_pause_on;
            got.ev.pause_off = ev_pause_off;
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result with none expected, phase %0d", $time, phase);
                mismatches++;
            end
            else
            begin
                want = awaited_results.pop_front();
                compare_field("phase", want.phase, got.phase);
                compare_field("is_playing", want.playing, got.playing);
                compare_field("is_paused", want.paused, got.paused);
                compare_field("forward", want.fwd, got.fwd);
                compare_field("ev_play", want.ev.play, got.ev.play);
                compare_field("ev_start", want.ev.start, got.ev.start);
                compare_field("ev_end", want.ev.end_pt, got.ev.end_pt);
                compare_field("ev_change", want.ev.change, got.ev.change);
                compare_field("ev_stop", want.ev.stop, got.ev.stop);
                compare_field("ev_pause_on", want.ev.pause_on, got.ev.pause_on);
                compare_field("ev_pause_off", want.ev.pause_off, got.ev.pause_off);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, awaited_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : stimulus
        play_mode_t         mode;
        bit                 looped;
        logic [RATE_W-1:0]  rate;
        bit                 clip;
        int unsigned        pick;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings, no clip: ticks and play are ignored, pause still works.
        queue_request(OP_TICK, 16'hFFFF, 0);
        queue_request(OP_PLAY, 0, 0);
        queue_request(OP_PAUSE, 0, 0);
        queue_request(OP_SET_POS, 0, 17'h1FFFF);
        queue_request(OP_STOP, 0, 0);
        queue_request(OP_RESET, 0, 0);
        drain();

        // Forward with loop: wrap on reaching the end, pause and resume.
        program_registers(MODE_FWD, 1'b1, 28'h0100000, 1'b1);
        queue_request(OP_PLAY, 0, 0);
        queue_request(OP_TICK, 0, 0);
        queue_request(OP_TICK, 8, 0);
        queue_request(OP_TICK, 8, 0);
        queue_request(OP_PAUSE, 0, 0);
        queue_request(OP_TICK, 8, 0);
        queue_request(OP_PLAY, 0, 0);
        queue_request(OP_PLAY, 0, 0);
        queue_request(OP_TICK, 16'hFFFF, 0);
        drain();

        // Reverse at the largest rate without loop: playback stops at once.
        program_registers(MODE_REV, 1'b0, 28'hFFFFFFF, 1'b1);
        queue_request(OP_RESET, 0, 0);
        queue_request(OP_PLAY, 0, 0);
        queue_request(OP_TICK, 1, 0);
        drain();

        // Ping-pong with loop: turn at the top, then restart past zero.
        program_registers(MODE_PP, 1'b1, 28'h0100000, 1'b1);
        queue_request(OP_RESET, 0, 0);
        queue_request(OP_PLAY, 0, 0);
        queue_request(OP_TICK, 12, 0);
        queue_request(OP_TICK, 12, 0);
        queue_request(OP_TICK, 9, 0);
        drain();

        for (int ph = 0; ph < 10; ph++)
        begin
            mode = play_mode_t'($urandom_range(0, 4));
            looped = $urandom_range(0, 1);
            case ($urandom_range(0, 5))
                0: rate = '0;
                1: rate = '1;
                2: rate = RATE_W'($urandom);
                default: rate = RATE_W'($urandom_range(1, 1 << 18));
            endcase
            clip = ($urandom_range(0, 9) != 0);
            program_registers(mode, looped, rate, clip);
            // The receiver starts a long hold-off as this phase's requests are offered.
            if (ph == 1 || ph == 6)
                hold_requests++;
            queue_request(OP_RESET, 0, 0);
            queue_request(OP_PLAY, 0, 0);
            for (int k = 0; k < 83; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    case ($urandom_range(0, 19))
                        0: queue_request(OP_TICK, 0, $urandom);
                        1, 2: queue_request(OP_TICK, $urandom_range(0, 65535), $urandom);
                        3: queue_request(OP_TICK, 65535, $urandom);
                        default: queue_request(OP_TICK, $urandom_range(0, 255), $urandom);
                    endcase
                end
                else if (pick < 70)
                    queue_request(OP_PLAY, $urandom, $urandom);
                else if (pick < 76)
                    queue_request(OP_PAUSE, $urandom, $urandom);
                else if (pick < 81)
                    queue_request(OP_STOP, $urandom, $urandom);
                else if (pick < 86)
                    queue_request(OP_RESET, $urandom, $urandom);
                else if ($urandom_range(0, 7) == 0)
                    queue_request(OP_SET_POS, $urandom, $urandom_range(0, 17'h1FFFF));
                else
                    queue_request(OP_SET_POS, $urandom, $urandom_range(0, 65536));
            end
            drain();
        end

        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
